/* rtl/hfpd_pkg.sv */
// Shared types, constants and decode functions for the hex-framed packet deframer.
package hfpd_pkg;

  localparam int SYNC_LEN   = 7;
  localparam int HEADER_LEN = 14;
  localparam int CHECK_LEN  = 4;
  localparam int DEST_END   = 4;
  localparam int SRC_END    = 8;
  localparam int KIND_END   = 10;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [15:0] CRC_POLY_RST  = 16'h1021;
  localparam logic [15:0] CRC_INIT_RST  = 16'hFFFF;
  localparam logic        CRC_REFL_RST  = 1'b0;
  localparam logic [15:0] CRC_FXOR_RST  = 16'h0000;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_HEADER = 3'd1,
    PH_DATA   = 3'd2,
    PH_GOOD   = 3'd3,
    PH_ERROR  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    REG_POLY = 2'd0,
    REG_INIT = 2'd1,
    REG_REFL = 2'd2,
    REG_FXOR = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] poly;
    logic [15:0] init;
    logic        refl;
    logic [15:0] fxor;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  parse_state;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        packet_done;
    logic [15:0] dest_object;
    logic [15:0] source_object;
    logic [7:0]  message_kind;
    logic [15:0] payload_length;
    logic [15:0] received_check;
    logic [15:0] computed_check;
  } result_t;

  // Sync string "===ssn1", one character per position.
  function automatic logic [7:0] sync_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0, 3'd1, 3'd2: ch = 8'h3D;
      3'd3, 3'd4:       ch = 8'h73;
      3'd5:             ch = 8'h6E;
      3'd6:             ch = 8'h31;
      default:          ch = 8'h00;
    endcase
    return ch;
  endfunction

  // {is_hex, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    case (c) inside
      [8'h30:8'h39]: r = {1'b1, 4'(c - 8'h30)};
      [8'h61:8'h66]: r = {1'b1, 4'(c - 8'h57)};
      [8'h41:8'h46]: r = {1'b1, 4'(c - 8'h37)};
      default:       r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/hfpd_ifs.sv */
// Channel interfaces: character input and decoded result output.
interface hfpd_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

interface hfpd_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  parse_state;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic        packet_done;
  logic [15:0] dest_object;
  logic [15:0] source_object;
  logic [7:0]  message_kind;
  logic [15:0] payload_length;
  logic [15:0] received_check;
  logic [15:0] computed_check;

  modport source (
    output valid, output parse_state, output payload_valid, output payload_byte,
    output payload_index, output packet_done, output dest_object, output source_object,
    output message_kind, output payload_length, output received_check,
    output computed_check, input ready
  );
  modport sink (
    input valid, input parse_state, input payload_valid, input payload_byte,
    input payload_index, input packet_done, input dest_object, input source_object,
    input message_kind, input payload_length, input received_check,
    input computed_check, output ready
  );
endinterface

/* rtl/hfpd_cfg.sv */
// APB register file holding the CRC variant settings.
module hfpd_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hfpd_pkg::ADDR_W-1:0] paddr,
  input  logic [hfpd_pkg::DATA_W-1:0] pwdata,
  output logic [hfpd_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output hfpd_pkg::cfg_t              cfg
);
  import hfpd_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poly <= CRC_POLY_RST;
      cfg.init <= CRC_INIT_RST;
      cfg.refl <= CRC_REFL_RST;
      cfg.fxor <= CRC_FXOR_RST;
    end else if (wr) begin
      case (idx)
        REG_POLY: cfg.poly <= pwdata[15:0];
        REG_INIT: cfg.init <= pwdata[15:0];
        REG_REFL: cfg.refl <= pwdata[0];
        REG_FXOR: cfg.fxor <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_POLY: prdata = {16'd0, cfg.poly};
      REG_INIT: prdata = {16'd0, cfg.init};
      REG_REFL: prdata = {31'd0, cfg.refl};
      REG_FXOR: prdata = {16'd0, cfg.fxor};
      default:  prdata = '0;
    endcase
  end

endmodule

/* rtl/hfpd_crc.sv */
// Byte-wide CRC-16 update, normal or reflected, polynomial from a register.
module hfpd_crc (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  input  logic [15:0] poly,
  input  logic        refl,
  output logic [15:0] crc_out
);
  logic [15:0] rpoly;
  logic [15:0] c;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      rpoly[i] = poly[15-i];
    end
    if (refl) begin
      c = crc_in ^ {8'd0, data};
      for (int i = 0; i < 8; i++) begin
        c = c[0] ? ((c >> 1) ^ rpoly) : (c >> 1);
      end
    end else begin
      c = crc_in ^ {data, 8'd0};
      for (int i = 0; i < 8; i++) begin
        c = c[15] ? ((c << 1) ^ poly) : (c << 1);
      end
    end
    crc_out = c;
  end

endmodule

/* rtl/hex_framed_packet_deframer_unit.sv */
// Hex-framed packet deframer: sync hunt, hex header decode, payload stream, CRC-16 check.
// Takes one character per cycle while char ready is high and gives one registered result
// word per accepted character. The header decode and the byte-wide CRC update are
// done in the same cycle the character is taken, so the block sustains one character
// per clock; a two-entry output stage (result register plus skid) keeps char ready high
// while one result waits, and drops ready only when both entries are full. CRC
// polynomial, initial value, bit order and final XOR are set through the APB port at
// byte addresses 0x0, 0x4, 0x8 and 0xC and should change only while the block is idle.
module hex_framed_packet_deframer_unit (
  input  logic                        clk,
  input  logic                        rst,
  hfpd_char_if.sink                   char_ch,
  hfpd_result_if.source               result_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hfpd_pkg::ADDR_W-1:0] paddr,
  input  logic [hfpd_pkg::DATA_W-1:0] pwdata,
  output logic [hfpd_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import hfpd_pkg::*;

  cfg_t cfg;

  hfpd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Parser state
  phase_t      phase, phase_next;
  logic [2:0]  sync_cnt, sync_cnt_next;
  logic [16:0] cnt, cnt_next;
  logic [15:0] acc, acc_next;
  logic [15:0] dest, dest_next;
  logic [15:0] src, src_next;
  logic [7:0]  kind, kind_next;
  logic [15:0] len, len_next;
  logic [15:0] crc, crc_next;
  logic [15:0] check, check_next;

  // Output stage
  result_t out_word, skid_word, res;
  logic    out_v, skid_v;

  logic        accept, pop;
  logic [7:0]  ch;
  logic [4:0]  hd;
  logic [16:0] cnt_inc;
  logic [16:0] len17;
  logic [15:0] acc_base;
  logic [15:0] acc_shift;
  logic [15:0] crc_upd;
  logic        sync_hit;
  logic        pvalid, done;
  logic [7:0]  pbyte;
  logic [15:0] pindex;

  assign ch            = char_ch.char_in;
  assign char_ch.ready = !skid_v;
  assign accept        = char_ch.valid && char_ch.ready;
  assign pop           = out_v && result_ch.ready;

  assign hd        = hex_digit(ch);
  assign cnt_inc   = cnt + 17'd1;
  assign len17     = {1'b0, len};
  // each header field and the check field start from an empty accumulator
  assign acc_base  = (((phase == PH_HEADER) && (cnt == 17'd0 || cnt == 17'(DEST_END) ||
                       cnt == 17'(SRC_END) || cnt == 17'(KIND_END))) ||
                      ((phase == PH_DATA) && (cnt == len17))) ? 16'd0 : acc;
  assign acc_shift = hd[4] ? {acc_base[11:0], hd[3:0]} : 16'd0;
  assign sync_hit  = (sync_cnt < 3'(SYNC_LEN)) && (ch == sync_char(sync_cnt));

  hfpd_crc u_crc (
    .crc_in  (crc),
    .data    (ch),
    .poly    (cfg.poly),
    .refl    (cfg.refl),
    .crc_out (crc_upd)
  );

  always_comb begin
    phase_next    = phase;
    sync_cnt_next = sync_cnt;
    cnt_next      = cnt;
    acc_next      = acc;
    dest_next     = dest;
    src_next      = src;
    kind_next     = kind;
    len_next      = len;
    crc_next      = crc;
    check_next    = check;
    pvalid        = 1'b0;
    pbyte         = 8'd0;
    pindex        = 16'd0;
    done          = 1'b0;

    case (phase)
      PH_HEADER: begin
        acc_next = acc_shift;
        cnt_next = cnt_inc;
        if (cnt_inc == 17'(DEST_END)) begin
          dest_next = acc_shift;
        end else if (cnt_inc == 17'(SRC_END)) begin
          src_next = acc_shift;
        end else if (cnt_inc == 17'(KIND_END)) begin
          kind_next = acc_shift[7:0];
        end else if (cnt_inc >= 17'(HEADER_LEN)) begin
          len_next   = acc_shift;
          phase_next = PH_DATA;
          cnt_next   = 17'd0;
          acc_next   = 16'd0;
          crc_next   = cfg.init;
        end
      end
      PH_DATA: begin
        if (cnt < len17) begin
          pvalid   = 1'b1;
          pbyte    = ch;
          pindex   = cnt[15:0];
          crc_next = crc_upd;
          cnt_next = cnt_inc;
        end else begin
          acc_next = acc_shift;
          cnt_next = cnt_inc;
          if (cnt_inc >= len17 + 17'(CHECK_LEN)) begin
            check_next    = acc_shift;
            done          = 1'b1;
            phase_next    = ((crc ^ cfg.fxor) == acc_shift) ? PH_GOOD : PH_ERROR;
            sync_cnt_next = 3'd0;
          end
        end
      end
      default: begin
        // hunt: a mismatch restarts without retesting this character
        sync_cnt_next = sync_hit ? sync_cnt + 3'd1 : 3'd0;
        if (sync_hit && (sync_cnt + 3'd1 == 3'(SYNC_LEN))) begin
          phase_next    = PH_HEADER;
          sync_cnt_next = 3'd0;
          cnt_next      = 17'd0;
          acc_next      = 16'd0;
        end
      end
    endcase

    res.parse_state    = phase_next;
    res.payload_valid  = pvalid;
    res.payload_byte   = pbyte;
    res.payload_index  = pindex;
    res.packet_done    = done;
    res.dest_object    = dest_next;
    res.source_object  = src_next;
    res.message_kind   = kind_next;
    res.payload_length = len_next;
    res.received_check = check_next;
    res.computed_check = crc_next ^ cfg.fxor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HUNT;
      sync_cnt <= 3'd0;
      cnt      <= 17'd0;
      acc      <= 16'd0;
      dest     <= 16'd0;
      src      <= 16'd0;
      kind     <= 8'd0;
      len      <= 16'd0;
      crc      <= 16'd0;
      check    <= 16'd0;
    end else if (accept) begin
      phase    <= phase_next;
      sync_cnt <= sync_cnt_next;
      cnt      <= cnt_next;
      acc      <= acc_next;
      dest     <= dest_next;
      src      <= src_next;
      kind     <= kind_next;
      len      <= len_next;
      crc      <= crc_next;
      check    <= check_next;
    end
  end

  // Result register with skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (pop) begin
      if (skid_v) begin
        skid_v <= 1'b0;
      end else begin
        out_v <= accept;
      end
    end else if (accept) begin
      if (out_v) begin
        skid_v <= 1'b1;
      end else begin
        out_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_v) begin
        out_word <= skid_word;
      end else if (accept) begin
        out_word <= res;
      end
    end else if (accept) begin
      if (out_v) begin
        skid_word <= res;
      end else begin
        out_word <= res;
      end
    end
  end

  assign result_ch.valid          = out_v;
  assign result_ch.parse_state    = out_word.parse_state;
  assign result_ch.payload_valid  = out_word.payload_valid;
  assign result_ch.payload_byte   = out_word.payload_byte;
  assign result_ch.payload_index  = out_word.payload_index;
  assign result_ch.packet_done    = out_word.packet_done;
  assign result_ch.dest_object    = out_word.dest_object;
  assign result_ch.source_object  = out_word.source_object;
  assign result_ch.message_kind   = out_word.message_kind;
  assign result_ch.payload_length = out_word.payload_length;
  assign result_ch.received_check = out_word.received_check;
  assign result_ch.computed_check = out_word.computed_check;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid entry valid with empty result register");

  a_header_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HEADER) |-> (cnt < 17'(HEADER_LEN)))
    else $error("header character count out of range");

  a_done_ends_packet: assert property (@(posedge clk) disable iff (rst)
    (accept && done) |=> (phase == PH_GOOD || phase == PH_ERROR))
    else $error("packet end did not settle to good or error");

  a_payload_in_data: assert property (@(posedge clk) disable iff (rst)
    (accept && pvalid) |-> (phase == PH_DATA && cnt < len17))
    else $error("payload byte outside payload phase");

endmodule
